// ----- hdl/orbb_pkg.sv -----
// Shared types, constants and helpers for the in-order block release buffer.
package orbb_pkg;

    localparam int PENDING_SLOTS = 16;
    localparam int SLOT_W        = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
    localparam int HDR_BYTES     = 4;
    localparam int ENTRY_W       = 48;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_AW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int IN_TDATA_W    = 80;
    localparam int OUT_TDATA_W   = 128;
    localparam int OUT_TUSER_W   = 2;

    typedef logic [SLOT_W-1:0] slot_idx_t;

    typedef enum logic [1:0] {
        ST_RELEASED = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_STALE    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_RELEASE = 2'd0,
        CMD_STORE   = 2'd1,
        CMD_DROP    = 2'd2,
        CMD_STALE   = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        slot_idx_t   idx;
        logic [31:0] seq;
        logic [13:0] wid;
        logic [17:0] len;
        logic [15:0] handle;
    } cmd_t;

    typedef struct packed {
        logic                     idle;
        logic [31:0]              next_seq;
        slot_idx_t                next_idx;
        logic [PENDING_SLOTS-1:0] slot_valid;
    } back_stat_t;

    typedef enum logic {
        B_IDLE  = 1'b0,
        B_DRAIN = 1'b1
    } back_state_t;

    // byte0 = id low, byte1 = length top bits over id high, byte2/3 = length bytes
    function automatic logic [31:0] pack_header(logic [13:0] wid, logic [17:0] len);
        return {len[7:0], len[15:8], len[17:16], wid[13:8], wid[7:0]};
    endfunction

endpackage

// ----- hdl/orbb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module orbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hdl/orbb_front.sv -----
// Front end: accepts input transactions and classifies them against the window.
module orbb_front (
    input  orbb_pkg::back_stat_t            stat,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [orbb_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                            q_empty,
    input  logic                            q_full,
    output logic                            q_push,
    output orbb_pkg::cmd_t                  q_cmd
);

    logic [31:0]             seq;
    logic [31:0]             seq_gap;
    logic                    wrapped;
    logic [orbb_pkg::SLOT_W:0] sum;
    orbb_pkg::slot_idx_t     idx;

    assign seq = s_tdata[31:0];

    // Window state is only final once the back end is idle with nothing queued.
    assign s_tready = stat.idle && q_empty && !q_full;
    assign q_push   = s_tvalid && s_tready;

    assign seq_gap = seq - stat.next_seq;
    assign wrapped = seq < stat.next_seq;
    assign sum     = {1'b0, stat.next_idx} + seq_gap[orbb_pkg::SLOT_W:0];

    // Slot of an ahead block; past the 2^32 wrap the sequence number itself is small.
    always_comb begin
        priority if (wrapped) begin
            idx = seq[orbb_pkg::SLOT_W-1:0];
        end else if (sum >= (orbb_pkg::SLOT_W+1)'(orbb_pkg::PENDING_SLOTS)) begin
            idx = orbb_pkg::SLOT_W'(sum - (orbb_pkg::SLOT_W+1)'(orbb_pkg::PENDING_SLOTS));
        end else begin
            idx = sum[orbb_pkg::SLOT_W-1:0];
        end
    end

    always_comb begin
        q_cmd.idx    = idx;
        q_cmd.seq    = seq;
        q_cmd.wid    = s_tdata[45:32];
        q_cmd.len    = s_tdata[63:46];
        q_cmd.handle = s_tdata[79:64];
        priority if (seq_gap == 32'd0) begin
            q_cmd.kind = orbb_pkg::CMD_RELEASE;
        end else if (seq_gap < 32'(orbb_pkg::PENDING_SLOTS)) begin
            q_cmd.kind = stat.slot_valid[idx] ? orbb_pkg::CMD_STALE : orbb_pkg::CMD_STORE;
        end else if (seq_gap[31]) begin
            q_cmd.kind = orbb_pkg::CMD_STALE;
        end else begin
            q_cmd.kind = orbb_pkg::CMD_DROP;
        end
    end

endmodule

// ----- hdl/orbb_queue.sv -----
// Short command queue between the front end and the back end.
module orbb_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  orbb_pkg::cmd_t push_data,
    input  logic           pop,
    output orbb_pkg::cmd_t pop_data,
    output logic           empty,
    output logic           full
);

    orbb_pkg::cmd_t                 entry_reg [orbb_pkg::QUEUE_DEPTH];
    logic [orbb_pkg::QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [orbb_pkg::QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [orbb_pkg::QUEUE_AW:0]    count_reg, count_next;
    logic                           do_push;
    logic                           do_pop;

    assign empty    = count_reg == '0;
    assign full     = count_reg == (orbb_pkg::QUEUE_AW+1)'(orbb_pkg::QUEUE_DEPTH);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == orbb_pkg::QUEUE_AW'(orbb_pkg::QUEUE_DEPTH-1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == orbb_pkg::QUEUE_AW'(orbb_pkg::QUEUE_DEPTH-1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hdl/orbb_back.sv -----
// Back end: executes commands, owns the slot table and drains waiting blocks.
module orbb_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_empty,
    input  orbb_pkg::cmd_t                   q_cmd,
    output logic                             q_pop,
    output orbb_pkg::back_stat_t             stat,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [orbb_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [orbb_pkg::OUT_TUSER_W-1:0] m_tuser,
    output logic                             m_tlast
);

    localparam int N = orbb_pkg::PENDING_SLOTS;

    orbb_pkg::back_state_t            state_reg, state_next;
    logic [31:0]                      next_seq_reg, next_seq_next;
    orbb_pkg::slot_idx_t              next_idx_reg, next_idx_next;
    logic [47:0]                      byte_count_reg, byte_count_next;
    logic [N-1:0]                     slot_valid_reg, slot_valid_next;
    logic                             m_valid_reg, m_valid_next;
    logic [orbb_pkg::OUT_TDATA_W-1:0] m_data_reg, m_data_next;
    orbb_pkg::status_t                m_user_reg, m_user_next;
    logic                             m_last_reg, m_last_next;

    logic                             out_free;
    logic                             do_pop;
    logic                             drain_go;
    logic                             rel;
    logic [31:0]                      adv_seq;
    orbb_pkg::slot_idx_t              adv_idx;
    logic [N-1:0]                     valid_clr;
    logic                             more;
    logic [13:0]                      rel_wid;
    logic [17:0]                      rel_len;
    logic [15:0]                      rel_handle;
    logic [47:0]                      rel_bytes;

    logic                             ram_we;
    logic                             ram_re;
    orbb_pkg::slot_idx_t              ram_raddr;
    logic [orbb_pkg::ENTRY_W-1:0]     ram_q;

    orbb_ram #(
        .WIDTH (orbb_pkg::ENTRY_W),
        .DEPTH (N)
    ) u_slot_ram (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (q_cmd.idx),
        .wr_data ({q_cmd.wid, q_cmd.len, q_cmd.handle}),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_q)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign do_pop   = (state_reg == orbb_pkg::B_IDLE) && !q_empty
                      && ((q_cmd.kind == orbb_pkg::CMD_STORE) || out_free);
    assign q_pop    = do_pop;
    assign drain_go = (state_reg == orbb_pkg::B_DRAIN) && out_free;
    assign rel      = (do_pop && (q_cmd.kind == orbb_pkg::CMD_RELEASE)) || drain_go;

    assign adv_seq = next_seq_reg + 32'd1;

    // Slot of next_seq+1; restarts at zero when the sequence number wraps.
    always_comb begin
        priority if (next_seq_reg == '1) begin
            adv_idx = '0;
        end else if (next_idx_reg == orbb_pkg::SLOT_W'(N-1)) begin
            adv_idx = '0;
        end else begin
            adv_idx = next_idx_reg + 1'b1;
        end
    end

    always_comb begin
        valid_clr = slot_valid_reg;
        if (drain_go) begin
            valid_clr[next_idx_reg] = 1'b0;
        end
    end

    assign more = valid_clr[adv_idx];

    assign rel_wid    = drain_go ? ram_q[47:34] : q_cmd.wid;
    assign rel_len    = drain_go ? ram_q[33:16] : q_cmd.len;
    assign rel_handle = drain_go ? ram_q[15:0]  : q_cmd.handle;
    assign rel_bytes  = byte_count_reg + 48'(orbb_pkg::HDR_BYTES) + 48'(rel_len);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            orbb_pkg::B_IDLE: begin
                if (rel && more) begin
                    state_next = orbb_pkg::B_DRAIN;
                end
            end
            orbb_pkg::B_DRAIN: begin
                if (drain_go && !more) begin
                    state_next = orbb_pkg::B_IDLE;
                end
            end
            default: state_next = orbb_pkg::B_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        next_seq_next   = next_seq_reg;
        next_idx_next   = next_idx_reg;
        byte_count_next = byte_count_reg;
        slot_valid_next = slot_valid_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        m_last_next     = m_last_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = adv_idx;
        if (rel) begin
            m_valid_next    = 1'b1;
            m_data_next     = {rel_bytes, next_seq_reg, rel_handle,
                               orbb_pkg::pack_header(rel_wid, rel_len)};
            m_user_next     = orbb_pkg::ST_RELEASED;
            m_last_next     = !more;
            next_seq_next   = adv_seq;
            next_idx_next   = adv_idx;
            byte_count_next = rel_bytes;
            slot_valid_next = valid_clr;
            ram_re          = more;
        end else if (do_pop && (q_cmd.kind == orbb_pkg::CMD_STORE)) begin
            ram_we                     = 1'b1;
            slot_valid_next[q_cmd.idx] = 1'b1;
        end else if (do_pop) begin
            m_valid_next = 1'b1;
            m_data_next  = {byte_count_reg, q_cmd.seq, q_cmd.handle, 32'd0};
            m_user_next  = (q_cmd.kind == orbb_pkg::CMD_DROP)
                           ? orbb_pkg::ST_DROPPED : orbb_pkg::ST_STALE;
            m_last_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= orbb_pkg::B_IDLE;
            next_seq_reg   <= '0;
            next_idx_reg   <= '0;
            byte_count_reg <= '0;
            slot_valid_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            next_seq_reg   <= next_seq_next;
            next_idx_reg   <= next_idx_next;
            byte_count_reg <= byte_count_next;
            slot_valid_reg <= slot_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign stat.idle       = state_reg == orbb_pkg::B_IDLE;
    assign stat.next_seq   = next_seq_reg;
    assign stat.next_idx   = next_idx_reg;
    assign stat.slot_valid = slot_valid_reg;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- hdl/in_order_block_release_buffer_unit.sv -----
// Top level of the in-order block release buffer.
//
// Input stream (s_*): one transaction per finished block, in any order.
// Output stream (m_*): releases in sequence order, plus one reject per block
// that is too far ahead (tuser 1) or stale/duplicate (tuser 2). tlast marks
// the final result caused by an input transaction; a block stored for later
// gives no result.
// With the output register free, an accepted input is written to the command
// queue and its first result is then registered in the output register.
// A new input is taken only once the back end has popped the previous command
// and is idle; the drain loop releases further waiting blocks, reading one
// slot-table RAM entry per cycle while the output register is free.
// A pending result sits in the output register and does not block the next
// input; while m_tready is low during a drain, the drain and s_tready hold.
// Reset (aresetn low, synchronous) empties the window, sets the expected
// sequence number and byte total to zero and drops any pending result. Slot
// valid bits are flip-flops, so no clearing pass follows reset.
module in_order_block_release_buffer_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // seq_number[31:0], worker_id[45:32], block_length[63:46], buffer_handle[79:64]
    input  logic [orbb_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // frame_header[31:0], out_handle[47:32], out_seq[79:48], bytes_total[127:80]
    output logic [orbb_pkg::OUT_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [orbb_pkg::OUT_TUSER_W-1:0] m_tuser,
    output logic                             m_tlast
);

    orbb_pkg::back_stat_t stat;
    orbb_pkg::cmd_t       push_cmd;
    orbb_pkg::cmd_t       pop_cmd;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_empty;
    logic                 q_full;

    orbb_front u_front (
        .stat     (stat),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_empty  (q_empty),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    orbb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_cmd),
        .pop       (q_pop),
        .pop_data  (pop_cmd),
        .empty     (q_empty),
        .full      (q_full)
    );

    orbb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_cmd    (pop_cmd),
        .q_pop    (q_pop),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- hdl/orbb_checker.sv -----
// Port-level checker for the release buffer, bound to the top level.
module orbb_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [orbb_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [orbb_pkg::OUT_TUSER_W-1:0] m_tuser,
    input logic                             m_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output transaction changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    a_reject_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != orbb_pkg::OUT_TUSER_W'(orbb_pkg::ST_RELEASED))
        |-> (m_tdata[31:0] == 32'd0) && m_tlast)
        else $error("reject carries a header or is not last");

    a_no_accept_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input accepted during a release run");

    a_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted in consecutive cycles");

endmodule

bind in_order_block_release_buffer_unit orbb_checker u_orbb_checker (.*);

// ----- tb/sv/in_order_block_release_buffer_unit_test.sv -----
// Self-checking testbench for the in-order block release buffer: directed table plus shuffled batches.
module in_order_block_release_buffer_unit_test;
    import orbb_pkg::*;

    localparam int NUM_DIRECTED = 24;
    localparam int NUM_RANDOM   = 200;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [15:0] handle;
        logic [17:0] len;
        logic [13:0] wid;
        logic [31:0] seq;
    } block_t;

    typedef struct packed {
        logic        last;
        status_t     st;
        logic [47:0] total;
        logic [31:0] seq;
        logic [15:0] handle;
        logic [31:0] hdr;
    } release_t;

    typedef struct packed {
        logic [31:0] seq;
        logic [13:0] wid;
        logic [17:0] len;
        logic [15:0] handle;
        logic        pinned;
        status_t     st;
        logic [31:0] hdr;
        logic [47:0] total;
    } dir_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tlast;

    in_order_block_release_buffer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Directed rows; pinned rows carry their single result typed in by hand.
    dir_row_t plan [NUM_DIRECTED] = '{
        '{32'd0, 14'h3FFF, 18'h3FFFF, 16'hFFFF, 1'b1, ST_RELEASED, 32'hFFFF_FFFF, 48'h4_0003},
        '{32'd1, 14'h0000, 18'h00000, 16'h0000, 1'b1, ST_RELEASED, 32'h0, 48'h4_0007},
        '{32'd0, 14'h1555, 18'h2AAAA, 16'h5555, 1'b1, ST_STALE, 32'h0, 48'h4_0007},
        '{32'd18, 14'h2AAA, 18'h15555, 16'hAAAA, 1'b1, ST_DROPPED, 32'h0, 48'h4_0007},
        '{32'h8000_0002, 14'h0001, 18'h00001, 16'h0001, 1'b1, ST_STALE, 32'h0, 48'h4_0007},
        '{32'h8000_0001, 14'h0002, 18'h00002, 16'h0002, 1'b1, ST_DROPPED, 32'h0, 48'h4_0007},
        '{32'hFFFF_FFFF, 14'h0003, 18'h00003, 16'h0003, 1'b1, ST_STALE, 32'h0, 48'h4_0007},
        '{32'd17, 14'h0123, 18'h12345, 16'h1717, 1'b0, ST_RELEASED, 32'h0, 48'h0},
        '{32'd17, 14'h0004, 18'h00004, 16'hD0D0, 1'b1, ST_STALE, 32'h0, 48'h4_0007},
        '{32'd5, 14'h2A55, 18'h25A3C, 16'h0505, 1'b0, ST_RELEASED, 32'h0, 48'h0},
        '{32'd4, 14'h1C0F, 18'h0F0F0, 16'h0404, 1'b0, ST_RELEASED, 32'h0, 48'h0},
        '{32'd3, 14'h00FF, 18'h30000, 16'h0303, 1'b0, ST_RELEASED, 32'h0, 48'h0},
        '{32'd2, 14'h3F00, 18'h000FF, 16'h0202, 1'b0, ST_RELEASED, 32'h0, 48'h0},
        '{32'd16, 14'h0010, 18'h00100, 16'h1616, 1'b0, ST_RELEASED, 32'h0, 48'h0},
        '{32'd15, 14'h0F0F, 18'h01000, 16'h1515, 1'b0, ST_RELEASED, 32'h0, 48'h0},
        '{32'd14, 14'h0E0E, 18'h10000, 16'h1414, 1'b0, ST_RELEASED, 32'h0, 48'h0},
        '{32'd13, 14'h0D0D, 18'h0ABCD, 16'h1313, 1'b0, ST_RELEASED, 32'h0, 48'h0},
        '{32'd12, 14'h0C0C, 18'h3FF00, 16'h1212, 1'b0, ST_RELEASED, 32'h0, 48'h0},
        '{32'd11, 14'h0B0B, 18'h00011, 16'h1111, 1'b0, ST_RELEASED, 32'h0, 48'h0},
        '{32'd10, 14'h0A0A, 18'h0A0A0, 16'h1010, 1'b0, ST_RELEASED, 32'h0, 48'h0},
        '{32'd9, 14'h0909, 18'h09090, 16'h0909, 1'b0, ST_RELEASED, 32'h0, 48'h0},
        '{32'd8, 14'h0808, 18'h08080, 16'h0808, 1'b0, ST_RELEASED, 32'h0, 48'h0},
        '{32'd7, 14'h0707, 18'h07070, 16'h0707, 1'b0, ST_RELEASED, 32'h0, 48'h0},
        '{32'd6, 14'h0606, 18'h06060, 16'h0606, 1'b0, ST_RELEASED, 32'h0, 48'h0}
    };

    // predictor state
    logic [PENDING_SLOTS-1:0] pend_valid = '0;
    block_t                   pend_block [PENDING_SLOTS];
    logic [31:0]              ord_next = '0;
    logic [47:0]              byte_sum = '0;

    release_t fresh [$];
    release_t expected_out [$];

    int  errors = 0;
    int  blocks_sent = 0;
    int  n_released = 0;
    int  n_rejected = 0;
    int  longest_run = 0;
    int  holds_done = 0;
    bit  hold_out = 0;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [31:0] frame_word(logic [13:0] wid, logic [17:0] len);
        logic [7:0] b0, b1, b2, b3;
        b0 = wid[7:0];
        b1 = {len[17:16], wid[13:8]};
        b2 = len[15:8];
        b3 = len[7:0];
        return {b3, b2, b1, b0};
    endfunction

    function automatic void emit_release(block_t b);
        release_t r;
        byte_sum    = byte_sum + 48'(HDR_BYTES) + 48'(b.len);
        r.hdr       = frame_word(b.wid, b.len);
        r.handle    = b.handle;
        r.seq       = b.seq;
        r.total     = byte_sum;
        r.st        = ST_RELEASED;
        r.last      = 1'b0;
        fresh.push_back(r);
        ord_next    = ord_next + 32'd1;
    endfunction

    function automatic void emit_reject(block_t b, status_t s);
        release_t r;
        r.hdr    = '0;
        r.handle = b.handle;
        r.seq    = b.seq;
        r.total  = byte_sum;
        r.st     = s;
        r.last   = 1'b0;
        fresh.push_back(r);
    endfunction

    function automatic void predict_block(block_t b);
        logic [31:0] seq_gap;
        int          idx;
        block_t      w;
        fresh.delete();
        seq_gap = b.seq - ord_next;
        if (seq_gap == 32'd0) begin
            emit_release(b);
            idx = int'(ord_next % 32'(PENDING_SLOTS));
            while (pend_valid[idx]) begin
                w = pend_block[idx];
                pend_valid[idx] = 1'b0;
                // released under whatever number is due now
                w.seq = ord_next;
                emit_release(w);
                idx = int'(ord_next % 32'(PENDING_SLOTS));
            end
        end else if (seq_gap < 32'(PENDING_SLOTS)) begin
            idx = int'(b.seq % 32'(PENDING_SLOTS));
            if (pend_valid[idx]) begin
                emit_reject(b, ST_STALE);
            end else begin
                pend_block[idx] = b;
                pend_valid[idx] = 1'b1;
            end
        end else if (seq_gap >= 32'h8000_0000) begin
            emit_reject(b, ST_STALE);
        end else begin
            emit_reject(b, ST_DROPPED);
        end
        if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
        if (fresh.size() > longest_run) longest_run = fresh.size();
    endfunction

    task automatic send_block(input block_t b, input bit pinned, input release_t typed,
                              input bit eager);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_block(b);
        if (pinned) expected_out.push_back(typed);
        else foreach (fresh[j]) expected_out.push_back(fresh[j]);
        blocks_sent++;
        gap = (eager || $urandom_range(0, 9) < 6) ? 0 : gap_len();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    function automatic block_t random_block();
        block_t b;
        b.seq    = $urandom;
        b.wid    = 14'($urandom);
        b.len    = 18'($urandom);
        b.handle = 16'($urandom);
        return b;
    endfunction

    // Up to one window's worth of consecutive blocks, shuffled unless sorted, with some noise mixed in.
    task automatic run_batch(input int k, input bit sorted, input bit eager);
        logic [31:0] base;
        int          order [PENDING_SLOTS];
        int          j, t, sw;
        block_t      b;
        base = ord_next;
        for (j = 0; j < k; j++) order[j] = j;
        if (!sorted) begin
            for (j = k - 1; j > 0; j--) begin
                t        = $urandom_range(0, j);
                sw       = order[j];
                order[j] = order[t];
                order[t] = sw;
            end
        end
        for (j = 0; j < k; j++) begin
            if ($urandom_range(0, 9) == 0) begin
                b = random_block();
                case ($urandom_range(0, 3))
                    0: b.seq = ord_next - $urandom_range(1, 32'h8000_0000);
                    1: b.seq = ord_next + $urandom_range(PENDING_SLOTS, 32'h7FFF_FFFF);
                    2: b.seq = base + 32'(order[$urandom_range(0, j)]);
                    default: b.seq = $urandom;
                endcase
                send_block(b, 1'b0, '0, eager);
            end
            b     = random_block();
            b.seq = base + 32'(order[j]);
            send_block(b, 1'b0, '0, eager);
        end
    endtask

    // receiver: random stalls, steady stretches, and one long hold-off on request
    initial begin : sink
        int span, stall;
        bit steady;
        m_tready = 1'b0;
        stall    = 0;
        forever begin
            span   = $urandom_range(10, 60);
            steady = ($urandom_range(0, 3) == 0);
            repeat (span) begin
                @(negedge aclk);
                if (hold_out) begin
                    hold_out = 0;
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge aclk);
                    holds_done++;
                end else if (steady) begin
                    m_tready <= 1'b1;
                end else if (stall > 0) begin
                    stall--;
                    m_tready <= 1'b0;
                end else if ($urandom_range(0, 99) < 25) begin
                    stall = gap_len() - 1;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    task automatic note_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got, input logic [31:0] seq);
        errors++;
        $display("%0t: %s mismatch on seq %0h: expected %0h, got %0h", $time, what, seq, want,
                 got);
    endtask

    always @(posedge aclk) begin : score
        release_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.hdr    = m_tdata[31:0];
            got.handle = m_tdata[47:32];
            got.seq    = m_tdata[79:48];
            got.total  = m_tdata[127:80];
            got.st     = status_t'(m_tuser);
            got.last   = m_tlast;
            if (got.st == ST_RELEASED) n_released++;
            else n_rejected++;
            if (expected_out.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, expected none, got seq %0h status %0d",
                         $time, got.seq, got.st);
            end else begin
                want = expected_out.pop_front();
                if (got.hdr !== want.hdr)
                    note_mismatch("frame_header", 64'(want.hdr), 64'(got.hdr), want.seq);
                if (got.handle !== want.handle)
                    note_mismatch("out_handle", 64'(want.handle), 64'(got.handle), want.seq);
                if (got.seq !== want.seq)
                    note_mismatch("out_seq", 64'(want.seq), 64'(got.seq), want.seq);
                if (got.total !== want.total)
                    note_mismatch("bytes_total", 64'(want.total), 64'(got.total), want.seq);
                if (got.st !== want.st)
                    note_mismatch("status", 64'(want.st), 64'(got.st), want.seq);
                if (got.last !== want.last)
                    note_mismatch("last_of_run", 64'(want.last), 64'(got.last), want.seq);
            end
        end
    end

    initial begin : stimulus
        block_t   b;
        release_t typed;
        int       i, nbatch, k;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < NUM_DIRECTED; i++) begin
            b.seq        = plan[i].seq;
            b.wid        = plan[i].wid;
            b.len        = plan[i].len;
            b.handle     = plan[i].handle;
            typed.hdr    = plan[i].hdr;
            typed.handle = plan[i].handle;
            typed.seq    = plan[i].seq;
            typed.total  = plan[i].total;
            typed.st     = plan[i].st;
            typed.last   = 1'b1;
            send_block(b, plan[i].pinned, typed, 1'b0);
        end
        // drop valid so the last block is not offered again while draining
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_out.size() != 0) @(posedge aclk);

        nbatch = 0;
        while (blocks_sent < NUM_DIRECTED + NUM_RANDOM) begin
            nbatch++;
            if (nbatch == 4) begin
                // in-order burst against a stalled output: the buffer must back up
                hold_out = 1;
                run_batch(PENDING_SLOTS, 1'b1, 1'b1);
            end else begin
                if (nbatch == 12) begin
                    @(negedge aclk);
                    s_tvalid <= 1'b0;
                    while (expected_out.size() != 0) @(posedge aclk);
                end
                k = ($urandom_range(0, 9) == 0) ? PENDING_SLOTS : $urandom_range(1, 8);
                run_batch(k, $urandom_range(0, 6) == 0, $urandom_range(0, 3) == 0);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (expected_out.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d blocks (%0d from the directed table) in shuffled windows with noise.",
                 blocks_sent, NUM_DIRECTED);
        $display("Checked %0d releases and %0d rejects; longest chained release %0d, holds %0d.",
                 n_released, n_rejected, longest_run, holds_done);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
